[design/mkce_pkg.sv]
`timescale 1ns / 1ps

package mkce_pkg;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHOW   = 2'd1,
    EV_COMMIT = 2'd2,
    EV_CAPS   = 2'd3
  } event_kind_t;

  // register indexes on the config port (byte address = 4 * index)
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_HOLD     = 2'd1;
  localparam logic [1:0] REG_CYCLE    = 2'd2;

  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] HOLD_RST     = 16'd800;
  localparam logic [15:0] CYCLE_RST    = 16'd800;

  localparam int          ROM_PADS = 12;
  localparam logic [6:0]  CARET    = 7'h5E;

  typedef struct packed {
    logic [11:0] touch_mask;
    logic [31:0] now_ms;
  } in_data_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [6:0]  char_code;
    logic [3:0]  pad_index;
    logic        caps_on;
  } out_data_t;

  // lowercase map, each string right-aligned (first character in the highest used byte)
  localparam logic [0:ROM_PADS-1][127:0] LOWER_ROM = '{
    128'("0^"),   128'("1abc"), 128'("2def"), 128'("3ghi"),
    128'("4jkl"), 128'("5mno"), 128'("6pqr"), 128'("7stu"),
    128'("8vwx"), 128'("9yz!#$%&*()_+=/?"), 128'("~~~~"), 128'("@@@@")
  };

  localparam logic [0:ROM_PADS-1][4:0] LEN_ROM = '{
    5'd2, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd16, 5'd4, 5'd4
  };

  // uppercase map differs from lowercase only in the letters
  function automatic logic [6:0] pad_char(input logic caps, input logic [3:0] pad,
                                          input logic [3:0] pos);
    logic [4:0] len;
    logic [3:0] idx;
    logic [7:0] c;
    if (pad >= 4'(ROM_PADS)) begin
      return 7'd0;
    end
    len = LEN_ROM[pad];
    idx = 4'(len - {1'b0, pos} - 5'd1);
    c = LOWER_ROM[pad][{idx, 3'b000} +: 8];
    if (caps && c >= 8'h61 && c <= 8'h7A) begin
      c = c - 8'h20;
    end
    return c[6:0];
  endfunction

endpackage

[design/multitap_keypad_char_entry.sv]
`timescale 1ns / 1ps

// Multi-tap keypad character entry.
// in_*: one poll per transfer, the touched-pad mask plus a millisecond timestamp.
// out_*: one result per poll: event kind (none, show, commit, caps toggle), the
// ASCII character, the pad involved and the caps lock state after the poll.
// cfg_*: APB-style port for debounce_ms (0x0), hold_ms (0x4) and cycle_ms (0x8);
// pready is tied high, writes land on the access cycle.
// Each poll is handled by one pass of logic from the press state registers and
// the incoming poll into the result register (or the skid register while the
// receiver stalls), and a poll can be taken every cycle while in_ready is high.
// A two-entry output stage (result register plus skid register) lets the block
// take one more poll while the receiver stalls; with both full, in_ready drops
// until out_ready returns.
// Reset (rst_n low, synchronous) restores the default timings, clears caps lock,
// the previous mask and all press timers, and empties the output stage.
module multitap_keypad_char_entry #(
  parameter int NUM_PADS  = 12,
  parameter int MAX_CHARS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mkce_pkg::in_data_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mkce_pkg::out_data_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import mkce_pkg::*;

  localparam logic [11:0] PAD_MASK = (NUM_PADS >= 12) ? 12'hFFF : 12'((1 << NUM_PADS) - 1);
  localparam logic [4:0]  MAX_LEN  = 5'(MAX_CHARS);

  logic [15:0] debounce_ms_r, hold_ms_r, cycle_ms_r;
  logic [11:0] prev_mask_r, prev_mask_nxt;
  logic        key_held_r, key_held_nxt;
  logic [3:0]  held_pad_r, held_pad_nxt;
  logic [3:0]  char_pos_r, char_pos_nxt;
  logic [31:0] press_start_r, press_start_nxt;
  logic [31:0] last_cycle_r, last_cycle_nxt;
  logic [31:0] last_accept_r, last_accept_nxt;
  logic        caps_lock_r, caps_lock_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  out_data_t   out_data_r, out_data_nxt;
  out_data_t   skid_data_r, skid_data_nxt;

  logic        in_fire, out_fire, cfg_wr;
  logic [11:0] cur, rises;
  logic [15:0] falls;
  logic        released, any_rise, pressed, cycled, debounce_ok, is_caps;
  logic [3:0]  rise_pad, eff_pad, eff_pos, nxt_pos, look_pad, look_pos;
  logic        eff_held;
  logic [31:0] eff_start;
  logic [4:0]  len, pos_inc;
  logic [6:0]  look_char;
  out_data_t   res;

  assign in_ready   = !skid_valid_r;
  assign in_fire    = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_fire   = out_valid_r && out_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_DEBOUNCE: cfg_prdata = {16'd0, debounce_ms_r};
      REG_HOLD:     cfg_prdata = {16'd0, hold_ms_r};
      REG_CYCLE:    cfg_prdata = {16'd0, cycle_ms_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // lowest rising pad
  always_comb begin
    rise_pad = 4'd0;
    for (int i = 11; i >= 0; i--) begin
      if (rises[i]) rise_pad = 4'(i);
    end
  end

  always_comb begin
    cur         = in_data.touch_mask & PAD_MASK;
    rises       = cur & ~prev_mask_r;
    falls       = {4'd0, ~cur & prev_mask_r};
    any_rise    = |rises;
    released    = key_held_r && falls[held_pad_r];
    debounce_ok = (in_data.now_ms - last_accept_r) >= {16'd0, debounce_ms_r};
    pressed     = !key_held_r && any_rise && debounce_ok;

    eff_held  = key_held_r || pressed;
    eff_pad   = pressed ? rise_pad : held_pad_r;
    eff_pos   = pressed ? 4'd0 : char_pos_r;
    eff_start = pressed ? in_data.now_ms : press_start_r;

    // a new press can also advance when hold_ms is zero
    cycled = !released && eff_held
             && ((in_data.now_ms - eff_start) >= {16'd0, hold_ms_r})
             && ((in_data.now_ms - last_cycle_r) >= {16'd0, cycle_ms_r});

    if (eff_pad >= 4'(ROM_PADS)) begin
      len = 5'd1;
    end else if (LEN_ROM[eff_pad] > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = LEN_ROM[eff_pad];
    end
    pos_inc = {1'b0, eff_pos} + 5'd1;
    nxt_pos = (pos_inc >= len) ? 4'd0 : pos_inc[3:0];

    look_pad  = released ? held_pad_r : eff_pad;
    look_pos  = released ? char_pos_r : (cycled ? nxt_pos : eff_pos);
    look_char = pad_char(caps_lock_r, look_pad, look_pos);
    is_caps   = released && (held_pad_r == 4'd0) && (look_char == CARET);

    caps_lock_nxt   = caps_lock_r ^ is_caps;
    prev_mask_nxt   = cur;
    key_held_nxt    = eff_held;
    held_pad_nxt    = eff_pad;
    char_pos_nxt    = cycled ? nxt_pos : eff_pos;
    press_start_nxt = eff_start;
    last_cycle_nxt  = cycled ? in_data.now_ms : last_cycle_r;
    last_accept_nxt = pressed ? in_data.now_ms : last_accept_r;

    res.caps_on = caps_lock_nxt;
    if (released) begin
      // release ends the press: timers restart from zero
      key_held_nxt    = 1'b0;
      held_pad_nxt    = 4'd0;
      char_pos_nxt    = 4'd0;
      press_start_nxt = 32'd0;
      last_cycle_nxt  = 32'd0;
      last_accept_nxt = 32'd0;
      res.event_kind  = is_caps ? EV_CAPS : EV_COMMIT;
      res.char_code   = is_caps ? 7'd0 : look_char;
      res.pad_index   = is_caps ? 4'd0 : held_pad_r;
    end else if (pressed || cycled) begin
      res.event_kind = EV_SHOW;
      res.char_code  = look_char;
      res.pad_index  = eff_pad;
    end else begin
      res.event_kind = EV_NONE;
      res.char_code  = 7'd0;
      res.pad_index  = 4'd0;
    end
  end

  // output register plus skid register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_fire) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = in_fire;
        skid_data_nxt  = res;
      end else begin
        out_valid_nxt = in_fire;
        out_data_nxt  = res;
      end
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_RST;
      hold_ms_r     <= HOLD_RST;
      cycle_ms_r    <= CYCLE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_DEBOUNCE: debounce_ms_r <= cfg_pwdata[15:0];
        REG_HOLD:     hold_ms_r     <= cfg_pwdata[15:0];
        REG_CYCLE:    cycle_ms_r    <= cfg_pwdata[15:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mask_r   <= 12'd0;
      key_held_r    <= 1'b0;
      held_pad_r    <= 4'd0;
      char_pos_r    <= 4'd0;
      press_start_r <= 32'd0;
      last_cycle_r  <= 32'd0;
      last_accept_r <= 32'd0;
      caps_lock_r   <= 1'b0;
    end else if (in_fire) begin
      prev_mask_r   <= prev_mask_nxt;
      key_held_r    <= key_held_nxt;
      held_pad_r    <= held_pad_nxt;
      char_pos_r    <= char_pos_nxt;
      press_start_r <= press_start_nxt;
      last_cycle_r  <= last_cycle_nxt;
      last_accept_r <= last_accept_nxt;
      caps_lock_r   <= caps_lock_nxt;
    end
  end

endmodule

[tb/sv/multitap_keypad_char_entry_tb.sv]
`timescale 1ns / 1ps

module multitap_keypad_char_entry_tb;
  import mkce_pkg::*;

  localparam int PADS            = 12;
  localparam int MAX_GLYPHS      = 16;
  localparam int QUIET_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_POLLS     = 210;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_data_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_data_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // keypad state as the block should hold it
  logic [15:0] debounce_cfg, hold_cfg, cycle_cfg;
  logic [11:0] last_mask;
  logic        pressing;
  logic [3:0]  press_pad, glyph_pos;
  logic [31:0] press_ms, advance_ms, accept_ms;
  logic        caps_state;
  out_data_t   pending_results[$];

  logic        idle_on = 1'b1;
  // stall requests from the test sequence, and how many the receiver has taken up
  int          hold_off_reqs = 0;
  int          hold_off_seen = 0;
  int          hold_off_left = 0;
  int          quiet_cycles = 0;
  int          err_count = 0;
  int          polls_sent = 0;
  int          results_checked = 0;
  int          kinds_seen[4];
  logic [31:0] sim_ms = '0;
  out_data_t   want_result;

  always #4 clk = ~clk;

  multitap_keypad_char_entry #(
    .NUM_PADS(PADS),
    .MAX_CHARS(MAX_GLYPHS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  function automatic string pad_glyphs(input logic [3:0] pad);
    string s;
    if (caps_state) begin
      case (pad)
        4'd0:    s = "0^";
        4'd1:    s = "1ABC";
        4'd2:    s = "2DEF";
        4'd3:    s = "3GHI";
        4'd4:    s = "4JKL";
        4'd5:    s = "5MNO";
        4'd6:    s = "6PQR";
        4'd7:    s = "7STU";
        4'd8:    s = "8VWX";
        4'd9:    s = "9YZ!#$%&*()_+=/?";
        4'd10:   s = "~~~~";
        4'd11:   s = "@@@@";
        default: s = "";
      endcase
    end else begin
      case (pad)
        4'd0:    s = "0^";
        4'd1:    s = "1abc";
        4'd2:    s = "2def";
        4'd3:    s = "3ghi";
        4'd4:    s = "4jkl";
        4'd5:    s = "5mno";
        4'd6:    s = "6pqr";
        4'd7:    s = "7stu";
        4'd8:    s = "8vwx";
        4'd9:    s = "9yz!#$%&*()_+=/?";
        4'd10:   s = "~~~~";
        4'd11:   s = "@@@@";
        default: s = "";
      endcase
    end
    return s;
  endfunction

  function automatic int glyph_count(input logic [3:0] pad);
    string s;
    s = pad_glyphs(pad);
    if (s.len() > MAX_GLYPHS) return MAX_GLYPHS;
    if (s.len() == 0) return 1;
    return s.len();
  endfunction

  function automatic logic [6:0] glyph_at(input logic [3:0] pad, input logic [3:0] pos);
    string s;
    byte   b;
    s = pad_glyphs(pad);
    if (int'(pos) >= s.len()) return 7'd0;
    b = s[pos];
    return b[6:0];
  endfunction

  function automatic void drop_press();
    pressing   = 1'b0;
    press_pad  = '0;
    glyph_pos  = '0;
    press_ms   = '0;
    advance_ms = '0;
    accept_ms  = '0;
  endfunction

  function automatic void reset_keypad_model();
    debounce_cfg = DEBOUNCE_RST;
    hold_cfg     = HOLD_RST;
    cycle_cfg    = CYCLE_RST;
    last_mask    = '0;
    caps_state   = 1'b0;
    drop_press();
  endfunction

  function automatic out_data_t predict_poll(input in_data_t poll);
    out_data_t   res;
    logic [11:0] cur;
    logic [31:0] now;
    logic [6:0]  c;
    logic        released;
    int          i;
    res = '0;
    res.event_kind = EV_NONE;
    cur = poll.touch_mask;
    now = poll.now_ms;
    released = 1'b0;
    for (i = 0; i < PADS && !released; i++) begin
      if (cur[i] && !last_mask[i] && !pressing &&
          32'(now - accept_ms) >= 32'(debounce_cfg)) begin
        pressing  = 1'b1;
        press_pad = 4'(i);
        press_ms  = now;
        accept_ms = now;
        glyph_pos = '0;
        res.event_kind = EV_SHOW;
        res.char_code  = glyph_at(4'(i), 4'd0);
        res.pad_index  = 4'(i);
      end
      // a release finishes the scan, so a higher pad that rises in the same poll is not pressed
      if (!cur[i] && last_mask[i] && pressing && press_pad == 4'(i)) begin
        c = glyph_at(press_pad, glyph_pos);
        if (press_pad == 4'd0 && c == CARET) begin
          caps_state = ~caps_state;
          res.event_kind = EV_CAPS;
          res.char_code  = '0;
          res.pad_index  = '0;
        end else begin
          res.event_kind = EV_COMMIT;
          res.char_code  = c;
          res.pad_index  = press_pad;
        end
        drop_press();
        released = 1'b1;
      end
    end
    last_mask = cur;
    if (!released && pressing && 32'(now - press_ms) >= 32'(hold_cfg) &&
        32'(now - advance_ms) >= 32'(cycle_cfg)) begin
      glyph_pos  = 4'((int'(glyph_pos) + 1) % glyph_count(press_pad));
      advance_ms = now;
      res.event_kind = EV_SHOW;
      res.char_code  = glyph_at(press_pad, glyph_pos);
      res.pad_index  = press_pad;
    end
    res.caps_on = caps_state;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // outputs change only at rising edges, so the falling edge sees a settled transfer
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, kind %0d char %0d pad %0d caps %0d", $time,
                 out_data.event_kind, out_data.char_code, out_data.pad_index,
                 out_data.caps_on);
        err_count++;
      end else begin
        want_result = pending_results.pop_front();
        check_field("event_kind", 32'(out_data.event_kind), 32'(want_result.event_kind));
        check_field("char_code", 32'(out_data.char_code), 32'(want_result.char_code));
        check_field("pad_index", 32'(out_data.pad_index), 32'(want_result.pad_index));
        check_field("caps_on", 32'(out_data.caps_on), 32'(want_result.caps_on));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_ready <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_seen != hold_off_reqs) begin
      hold_off_seen <= hold_off_reqs;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 7);
    end
  end

  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_poll(input logic [11:0] mask, input logic [31:0] ms);
    in_data_t  poll;
    out_data_t expected;
    int        gap;
    poll.touch_mask = mask;
    poll.now_ms     = ms;
    if (idle_on && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= poll;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    expected = predict_poll(poll);
    pending_results.push_back(expected);
    kinds_seen[expected.event_kind]++;
    polls_sent++;
  endtask

  // called right at the edge of the last transfer, so valid drops before the next edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timing(input logic [1:0] reg_idx, input logic [15:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (reg_idx)
      REG_DEBOUNCE: debounce_cfg = value;
      REG_HOLD:     hold_cfg = value;
      REG_CYCLE:    cycle_cfg = value;
      default:      ;
    endcase
  endtask

  task automatic set_timing(input logic [15:0] debounce, input logic [15:0] hold,
                            input logic [15:0] cycle);
    wait_drained();
    write_timing(REG_DEBOUNCE, debounce);
    write_timing(REG_HOLD, hold);
    write_timing(REG_CYCLE, cycle);
    @(posedge clk);
  endtask

  // press one pad, keep it down for a while with other pads brushed now and then, release
  task automatic type_keystroke(input int step_max);
    int          pad;
    int          holds;
    logic [11:0] mask;
    logic [11:0] extra;
    pad   = $urandom_range(0, PADS - 1);
    holds = $urandom_range(0, (pad == 9) ? 24 : 8);
    mask  = 12'(1 << pad);
    extra = ($urandom_range(3) == 0) ? 12'($urandom) : '0;
    sim_ms += $urandom_range(0, step_max);
    send_poll(mask, sim_ms);
    repeat (holds) begin
      sim_ms += $urandom_range(0, step_max);
      send_poll(mask | (extra & 12'($urandom)), sim_ms);
    end
    sim_ms += $urandom_range(0, step_max);
    send_poll(extra & 12'($urandom) & ~mask, sim_ms);
  endtask

  task automatic noise_burst(input int step_max);
    int polls;
    polls = $urandom_range(1, 6);
    repeat (polls) begin
      if ($urandom_range(9) == 0) sim_ms = $urandom;
      else sim_ms += $urandom_range(0, step_max);
      send_poll(12'($urandom), sim_ms);
    end
  endtask

  task automatic test_default_timing();
    send_poll(12'h002, 32'd30);    // debounce measured from time zero
    send_poll(12'h000, 32'd40);
    send_poll(12'h002, 32'd100);
    send_poll(12'h002, 32'd900);
    send_poll(12'h002, 32'd1700);
    send_poll(12'h000, 32'd1750);
    send_poll(12'h001, 32'd1760);  // accept time was cleared by the commit
    send_poll(12'h001, 32'd2560);
    send_poll(12'h000, 32'd2570);  // caret release toggles caps
    send_poll(12'hFFF, 32'd2600);
    send_poll(12'hFFE, 32'd2610);
    send_poll(12'h000, 32'd2650);
    send_poll(12'h004, 32'd2700);
    send_poll(12'h020, 32'd2710);  // pad 5 rises as pad 2 releases and is never seen
    send_poll(12'h200, 32'd3000);
    wait_drained();
  endtask

  task automatic test_zero_timing();
    set_timing(16'd0, 16'd0, 16'd0);
    send_poll(12'h200, 32'd3000);
    send_poll(12'h200, 32'd3000);
    send_poll(12'h000, 32'd3000);
    send_poll(12'h008, 32'd3000);  // show and advance in one poll
    send_poll(12'h000, 32'hFFFF_FFFF);
    send_poll(12'h800, 32'h0000_0005);
    send_poll(12'h000, 32'h0000_0005);
    wait_drained();
  endtask

  task automatic test_max_timing();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_poll(12'h400, 32'd10);
    send_poll(12'h000, 32'd20);
    send_poll(12'h400, 32'd65535);
    send_poll(12'h400, 32'd131070);
    send_poll(12'h000, 32'd131071);
    wait_drained();
  endtask

  task automatic test_random_entry();
    int          phase;
    int          first_poll;
    int          step_max;
    logic [15:0] d, h, c;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          set_timing(16'd0, 16'd0, 16'd0);
          step_max = 4;
        end
        1: begin
          set_timing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)),
                     16'($urandom_range(1, 40)));
          step_max = 30;
        end
        2: begin
          set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
          step_max = 40000;
          idle_on <= 1'b0;
        end
        3: begin
          d = 16'($urandom);
          h = 16'($urandom);
          c = 16'($urandom);
          set_timing(d, h, c);
          step_max = int'((h > c) ? h : c) / 2 + 8;
          idle_on <= 1'b1;
        end
        default: begin
          set_timing(DEBOUNCE_RST, HOLD_RST, CYCLE_RST);
          step_max = 600;
        end
      endcase
      sim_ms = $urandom;
      first_poll = polls_sent;
      while (polls_sent - first_poll < PHASE_POLLS) begin
        if ($urandom_range(99) < 80) type_keystroke(step_max);
        else noise_burst(step_max);
      end
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    hold_off_reqs++;
    repeat (5) type_keystroke(600);
    wait_drained();
  endtask

  initial begin
    reset_keypad_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_timing();
    test_zero_timing();
    test_max_timing();
    test_random_entry();
    test_output_backpressure();
    wait_drained();
    repeat (5) @(posedge clk);
    $display("%0d polls, %0d results checked: %0d show, %0d commit, %0d caps, %0d idle",
             polls_sent, results_checked, kinds_seen[EV_SHOW], kinds_seen[EV_COMMIT],
             kinds_seen[EV_CAPS], kinds_seen[EV_NONE]);
    $display("timings: reset values, all zero, all 0xFFFF, random; one %0d-cycle stall",
             HOLD_OFF_CYCLES);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/mkce_pkg.sv
design/multitap_keypad_char_entry.sv
tb/sv/multitap_keypad_char_entry_tb.sv
